>>> design/trvm_pkg.sv
// shared types, opcodes and a helper function for the register machine execute core
// no dependencies; trvm_offset_pipe, trvm_exec and the top level refer to this package by scoped names
package trvm_pkg;

    // opcodes
    localparam logic [2:0] OP_LOADI   = 3'd0;
    localparam logic [2:0] OP_ADDI    = 3'd1;
    localparam logic [2:0] OP_COMPARE = 3'd2;
    localparam logic [2:0] OP_JUMP    = 3'd3;
    localparam logic [2:0] OP_BRANCH  = 3'd4;
    localparam logic [2:0] OP_EXIT    = 3'd5;

    // fixed field widths of one instruction and one result
    localparam int REG_NUM_W = 5;
    localparam int DATA_W    = 32;
    localparam int PC_OUT_W  = 8;

    // one instruction as it moves down the pipeline
    typedef struct packed {
        logic [2:0]           mode;
        logic [REG_NUM_W-1:0] dest_reg;
        logic [REG_NUM_W-1:0] src_a;
        logic [REG_NUM_W-1:0] src_b;
        logic [DATA_W-1:0]    literal;
    } item_t;

    // one result
    typedef struct packed {
        logic [PC_OUT_W-1:0]  next_pc;
        logic                 halted;
        logic                 wrote;
        logic [REG_NUM_W-1:0] write_index;
        logic [DATA_W-1:0]    write_value;
    } res_t;

    // register number folded into the register count by repeated subtraction
    function automatic logic [REG_NUM_W-1:0] reg_sel(
        input logic [REG_NUM_W-1:0] num,
        input int unsigned          count
    );
        logic [REG_NUM_W-1:0] v;
        v = num;
        for (int i = 0; i < 8; i++)
        begin
            if (32'(v) >= count)
            begin
                v = v - REG_NUM_W'(count);
            end
        end
        return v;
    endfunction

endpackage

>>> design/trvm_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module trvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, returns old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/trvm_offset_pipe.sv
// front pipeline: folds register numbers and reduces the pc offset plus one
// modulo the program depth over three stages; uses trvm_pkg
module trvm_offset_pipe #(
    parameter int PROGRAM_DEPTH  = 256,
    parameter int REGISTER_COUNT = 32,
    parameter int PW             = $clog2(PROGRAM_DEPTH)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  trvm_pkg::item_t in_item,
    output logic            in_stall,
    input  logic            take,
    output logic            c_valid,
    output trvm_pkg::item_t c_item,
    output logic [PW-1:0]   c_off
);

    logic [PW-1:0] tbl [4][256];
    logic [PW-1:0] look [4];
    trvm_pkg::item_t in_red;

    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic c_valid_reg, c_valid_next;
    logic a_free, b_free, c_free;
    logic a_load, b_load, c_load;

    trvm_pkg::item_t a_item_reg, b_item_reg, c_item_reg;
    logic [PW-1:0] a_t_reg [4];
    logic [PW-1:0] b_p0_reg, b_p1_reg;
    logic [PW-1:0] c_off_reg;

    // sum of two residues, brought back below the depth
    function automatic logic [PW-1:0] mod_add(input logic [PW-1:0] x, input logic [PW-1:0] y);
        logic [PW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= (PW+1)'(PROGRAM_DEPTH))
        begin
            s = s - (PW+1)'(PROGRAM_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    // residue tables, one per literal byte; the top byte carries the sign and the plus one
    for (genvar gk = 0; gk < 4; gk++)
    begin : g_tbl
        for (genvar gb = 0; gb < 256; gb++)
        begin : g_ent
            localparam longint Weight = longint'(1) << (8 * gk);
            localparam longint SignAdj = (gk == 3 && gb >= 128) ? (longint'(1) << 32) : 0;
            localparam longint Raw = longint'(gb) * Weight - SignAdj + ((gk == 3) ? 1 : 0);
            localparam longint Res = ((Raw % PROGRAM_DEPTH) + PROGRAM_DEPTH) % PROGRAM_DEPTH;
            assign tbl[gk][gb] = PW'(Res);
        end
    end

    // table lookups from the incoming literal
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            look[k] = tbl[k][in_item.literal[8*k +: 8]];
        end
    end

    // register numbers folded into the register count
    always_comb
    begin
        in_red          = in_item;
        in_red.dest_reg = trvm_pkg::reg_sel(in_item.dest_reg, REGISTER_COUNT);
        in_red.src_a    = trvm_pkg::reg_sel(in_item.src_a, REGISTER_COUNT);
        in_red.src_b    = trvm_pkg::reg_sel(in_item.src_b, REGISTER_COUNT);
    end

    // stage flow control
    assign c_free = !c_valid_reg || take;
    assign b_free = !b_valid_reg || c_free;
    assign a_free = !a_valid_reg || b_free;
    assign a_load = in_valid && a_free;
    assign b_load = a_valid_reg && b_free;
    assign c_load = b_valid_reg && c_free;
    assign in_stall = !a_free;

    assign a_valid_next = a_free ? in_valid : 1'b1;
    assign b_valid_next = b_free ? a_valid_reg : 1'b1;
    assign c_valid_next = c_free ? b_valid_reg : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // stage payloads: lookups, pair sums, final residue
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_item_reg <= in_red;
            for (int k = 0; k < 4; k++)
            begin
                a_t_reg[k] <= look[k];
            end
        end
        if (b_load)
        begin
            b_item_reg <= a_item_reg;
            b_p0_reg   <= mod_add(a_t_reg[0], a_t_reg[1]);
            b_p1_reg   <= mod_add(a_t_reg[2], a_t_reg[3]);
        end
        if (c_load)
        begin
            c_item_reg <= b_item_reg;
            c_off_reg  <= mod_add(b_p0_reg, b_p1_reg);
        end
    end

    assign c_valid = c_valid_reg;
    assign c_item  = c_item_reg;
    assign c_off   = c_off_reg;

endmodule

>>> design/trvm_regfile.sv
// register file: two ram copies for two reads, valid bits for the zero reset,
// and a bypass for a write landing on the read edge; uses trvm_ram
module trvm_regfile #(
    parameter int REGISTER_COUNT = 32,
    parameter int IW             = $clog2(REGISTER_COUNT)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_a,
    input  logic [IW-1:0] rd_b,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_idx,
    input  logic [31:0]   wr_data,
    output logic [31:0]   opnd_a,
    output logic [31:0]   opnd_b
);

    logic [REGISTER_COUNT-1:0] vld_reg;
    logic a_hit_reg, b_hit_reg;
    logic a_vld_reg, b_vld_reg;
    logic [31:0] a_fwd_reg, b_fwd_reg;
    logic [31:0] q_a, q_b;

    trvm_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_ram_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_a),
        .rdata (q_a)
    );

    trvm_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_ram_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_b),
        .rdata (q_b)
    );

    // written-once marks and read-side hit flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            a_hit_reg <= 1'b0;
            b_hit_reg <= 1'b0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                a_hit_reg <= wr_en && (wr_idx == rd_a);
                b_hit_reg <= wr_en && (wr_idx == rd_b);
                a_vld_reg <= vld_reg[rd_a];
                b_vld_reg <= vld_reg[rd_b];
            end
        end
    end

    // bypass data for a write on the read edge
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            a_fwd_reg <= wr_data;
            b_fwd_reg <= wr_data;
        end
    end

    assign opnd_a = a_hit_reg ? a_fwd_reg : (a_vld_reg ? q_a : 32'd0);
    assign opnd_b = b_hit_reg ? b_fwd_reg : (b_vld_reg ? q_b : 32'd0);

endmodule

>>> design/trvm_exec.sv
// execute stage: holds one instruction with its operands, updates pc and halt,
// drives the register write and the result register; uses trvm_pkg
module trvm_exec #(
    parameter int PROGRAM_DEPTH  = 256,
    parameter int REGISTER_COUNT = 32,
    parameter int PW             = $clog2(PROGRAM_DEPTH),
    parameter int IW             = $clog2(REGISTER_COUNT)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            c_valid,
    input  trvm_pkg::item_t c_item,
    input  logic [PW-1:0]   c_off,
    output logic            x_free,
    input  logic [31:0]     opnd_a,
    input  logic [31:0]     opnd_b,
    output logic            wr_en,
    output logic [IW-1:0]   wr_idx,
    output logic [31:0]     wr_data,
    input  logic            out_stall,
    output logic            out_valid,
    output trvm_pkg::res_t  res
);

    logic x_valid_reg, x_valid_next;
    trvm_pkg::item_t x_item_reg;
    logic [PW-1:0] x_off_reg;
    logic x_load, x_move, o_free;

    logic [PW-1:0] pc_reg, pc_next;
    logic halt_reg, halt_next;
    logic out_valid_reg, out_valid_next;
    trvm_pkg::res_t res_reg, res_next;

    logic [PW-1:0] pc_inc, pc_jmp;
    logic [PW:0] jmp_sum;
    logic [31:0] pc_ext;
    logic wrote;
    logic [31:0] value;

    // flow control
    assign o_free = !out_valid_reg || !out_stall;
    assign x_move = x_valid_reg && o_free;
    assign x_free = !x_valid_reg || o_free;
    assign x_load = c_valid && x_free;
    assign x_valid_next = x_free ? c_valid : 1'b1;
    assign out_valid_next = x_move || (out_valid_reg && out_stall);

    // pc candidates, both wrapped into the program depth
    assign pc_inc = (pc_reg == PW'(PROGRAM_DEPTH - 1)) ? '0 : pc_reg + PW'(1);
    assign jmp_sum = {1'b0, pc_reg} + {1'b0, x_off_reg};
    assign pc_jmp = (jmp_sum >= (PW+1)'(PROGRAM_DEPTH))
                  ? PW'(jmp_sum - (PW+1)'(PROGRAM_DEPTH)) : jmp_sum[PW-1:0];

    // instruction decode and execute
    always_comb
    begin
        wrote     = 1'b0;
        value     = 32'd0;
        pc_next   = pc_reg;
        halt_next = halt_reg;
        if (!halt_reg)
        begin
            case (x_item_reg.mode)
                trvm_pkg::OP_LOADI:
                begin
                    wrote   = 1'b1;
                    value   = x_item_reg.literal;
                    pc_next = pc_inc;
                end
                trvm_pkg::OP_ADDI:
                begin
                    wrote   = 1'b1;
                    value   = opnd_a + x_item_reg.literal;
                    pc_next = pc_inc;
                end
                trvm_pkg::OP_COMPARE:
                begin
                    wrote   = 1'b1;
                    value   = (opnd_a == opnd_b) ? 32'd1 : 32'd0;
                    pc_next = pc_inc;
                end
                trvm_pkg::OP_JUMP:
                begin
                    pc_next = pc_jmp;
                end
                trvm_pkg::OP_BRANCH:
                begin
                    pc_next = (opnd_a != 32'd0) ? pc_jmp : pc_inc;
                end
                trvm_pkg::OP_EXIT:
                begin
                    halt_next = 1'b1;
                end
                default:
                begin
                    pc_next = pc_inc;
                end
            endcase
        end
    end

    // result assembly
    assign pc_ext = 32'(pc_next);
    always_comb
    begin
        res_next.next_pc     = pc_ext[7:0];
        res_next.halted      = halt_next;
        res_next.wrote       = wrote;
        res_next.write_index = wrote ? x_item_reg.dest_reg : '0;
        res_next.write_value = wrote ? value : 32'd0;
    end

    // register write back on transfer into the result register
    assign wr_en   = x_move && wrote;
    assign wr_idx  = IW'(x_item_reg.dest_reg);
    assign wr_data = value;

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
        end
        else
        begin
            x_valid_reg   <= x_valid_next;
            out_valid_reg <= out_valid_next;
            if (x_move)
            begin
                pc_reg   <= pc_next;
                halt_reg <= halt_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (x_load)
        begin
            x_item_reg <= c_item;
            x_off_reg  <= c_off;
        end
        if (x_move)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

>>> design/tiny_register_vm_execute_core.sv
// top level of the register machine execute core
// depends on trvm_pkg, trvm_offset_pipe, trvm_regfile, trvm_exec and trvm_ram
//
// Executes one instruction per transfer on the input channel and returns one result
// per instruction, in order. The core takes a new instruction every cycle while the
// output is not stalled. Three front stages fold register numbers and reduce the pc
// offset modulo the program depth through per-byte residue tables, the two source
// registers are read from the register file rams as an instruction enters the
// execute stage, and the execute stage updates pc, halt and the register file while
// loading the result register. A write into the register file is bypassed to a read
// issued on the same edge, so back-to-back dependent instructions see the new value.
// The register file reads as zero after reset through per-register valid bits; there
// is no clearing pass and the core accepts input as soon as reset is released.
// Once an exit executes, later instructions return the held pc with halted set and
// write nothing.
module tiny_register_vm_execute_core #(
    parameter int REGISTER_COUNT = 32,
    parameter int PROGRAM_DEPTH  = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         mode,
    input  logic [4:0]         dest_reg,
    input  logic [4:0]         src_a,
    input  logic [4:0]         src_b,
    input  logic signed [31:0] literal,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         next_pc,
    output logic               halted,
    output logic               wrote,
    output logic [4:0]         write_index,
    output logic signed [31:0] write_value
);

    localparam int IW = $clog2(REGISTER_COUNT);
    localparam int PW = $clog2(PROGRAM_DEPTH);

    trvm_pkg::item_t in_item;
    trvm_pkg::item_t c_item;
    trvm_pkg::res_t res;
    logic c_valid, x_free, rd_en;
    logic [PW-1:0] c_off;
    logic [31:0] opnd_a, opnd_b;
    logic wr_en;
    logic [IW-1:0] wr_idx;
    logic [31:0] wr_data;

    // input fields gathered into one item
    always_comb
    begin
        in_item.mode     = mode;
        in_item.dest_reg = dest_reg;
        in_item.src_a    = src_a;
        in_item.src_b    = src_b;
        in_item.literal  = literal;
    end

    trvm_offset_pipe #(
        .PROGRAM_DEPTH  (PROGRAM_DEPTH),
        .REGISTER_COUNT (REGISTER_COUNT),
        .PW             (PW)
    ) u_offset_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_item  (in_item),
        .in_stall (in_stall),
        .take     (x_free),
        .c_valid  (c_valid),
        .c_item   (c_item),
        .c_off    (c_off)
    );

    // operand read issued as an instruction enters the execute stage
    assign rd_en = c_valid && x_free;

    trvm_regfile #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .IW             (IW)
    ) u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_a    (IW'(c_item.src_a)),
        .rd_b    (IW'(c_item.src_b)),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .opnd_a  (opnd_a),
        .opnd_b  (opnd_b)
    );

    trvm_exec #(
        .PROGRAM_DEPTH  (PROGRAM_DEPTH),
        .REGISTER_COUNT (REGISTER_COUNT),
        .PW             (PW),
        .IW             (IW)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .c_valid   (c_valid),
        .c_item    (c_item),
        .c_off     (c_off),
        .x_free    (x_free),
        .opnd_a    (opnd_a),
        .opnd_b    (opnd_b),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res       (res)
    );

    // result fields
    assign next_pc     = res.next_pc;
    assign halted      = res.halted;
    assign wrote       = res.wrote;
    assign write_index = res.write_index;
    assign write_value = $signed(res.write_value);

    // a halted core never reports a register write
    a_no_write_when_halted: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !(halted && wrote)
    ) else $error("register write reported while halted");

    // write fields are zero when nothing was written
    a_quiet_write_fields: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !wrote) |-> ((write_index == 5'd0) && (write_value == 32'sd0))
    ) else $error("write fields not cleared without a write");

    // halt is sticky across result transfers
    a_halt_sticky: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && halted) |=> (!out_valid || halted)
    ) else $error("halt flag dropped after being set");

    // the register file is only written while the execute stage hands off a result
    a_write_needs_room: assert property (
        @(posedge clk) disable iff (!rst_n)
        wr_en |-> (!out_valid || !out_stall)
    ) else $error("register write while the result register is blocked");

endmodule
